// File: rtl/touch_key_long_press_classifier_top_macros.svh
// assertion macros used by tklp_back
`ifndef TOUCH_KEY_LONG_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define TOUCH_KEY_LONG_PRESS_CLASSIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TKLP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TKLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TKLP_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TKLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/tklp_pkg.sv
`default_nettype none

package tklp_pkg;

    // reported key events
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_POWER = 3'd1,
        EV_SPEED = 3'd2,
        EV_TIMER = 3'd3,
        EV_MODE  = 3'd4,
        EV_WIFI  = 3'd5,
        EV_BUSY  = 3'd6
    } tklp_event_t;

    // item kinds decided by the front part
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_BUSY  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_SCAN  = 2'd3
    } tklp_kind_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_POWER_CODE = 3'd0,
        REG_SPEED_CODE = 3'd1,
        REG_TIMER_CODE = 3'd2,
        REG_MODE_CODE  = 3'd3,
        REG_WIFI_CODE  = 3'd4,
        REG_HOLD_TICKS = 3'd5,
        REG_SHORT_REP  = 3'd6,
        REG_LONG_REP   = 3'd7
    } tklp_reg_t;

    localparam int CODE_W    = 8;
    localparam int HOLD_W    = 16;
    localparam int REP_W     = 8;
    localparam int CFG_W     = 16;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 8;

    // queue depth, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [CODE_W-1:0] RST_POWER_CODE = 8'd1;
    localparam logic [CODE_W-1:0] RST_SPEED_CODE = 8'd2;
    localparam logic [CODE_W-1:0] RST_TIMER_CODE = 8'd4;
    localparam logic [CODE_W-1:0] RST_MODE_CODE  = 8'd8;
    localparam logic [CODE_W-1:0] RST_WIFI_CODE  = 8'd16;
    localparam logic [HOLD_W-1:0] RST_HOLD_TICKS = 16'd50;
    localparam logic [REP_W-1:0]  RST_SHORT_REP  = 8'd20;
    localparam logic [REP_W-1:0]  RST_LONG_REP   = 8'd40;

    // one classified item
    typedef struct packed {
        tklp_kind_t        kind;
        logic [CODE_W-1:0] status_main;
        logic [CODE_W-1:0] status_aux;
    } tklp_entry_t;

    // front to queue write request
    typedef struct packed {
        logic        push;
        tklp_entry_t entry;
    } tklp_push_t;

    // queue status toward both sides
    typedef struct packed {
        logic full;
        logic valid;
    } tklp_qstat_t;

endpackage

`default_nettype wire

// File: rtl/touch_key_long_press_classifier_top.sv
// a scan transfer is written into the queue, then popped by the back part into the output register
// throughput: one item per cycle unless a result waits in the output slot with m_tready low;
// and ticks retire without using the output slot
// reset: asynchronous, active low; clears the queue, state and output valid flag and
// returns every configuration register to its default code and threshold
`default_nettype none

module touch_key_long_press_classifier_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tklp_pkg::IN_DATA_W-1:0]  s_tdata,   // status_main, status_aux, motor_busy
    input  wire logic                            s_tuser,   // mode
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tklp_pkg::OUT_DATA_W-1:0]      m_tdata,   // key_event, key_touched
    input  wire logic                            cfg_we,
    input  wire logic [2:0]                      cfg_index,
    input  wire logic [tklp_pkg::CFG_W-1:0]      cfg_data
);

    tklp_pkg::tklp_push_t  wr;
    tklp_pkg::tklp_qstat_t qstat;
    tklp_pkg::tklp_entry_t head;
    logic                  pop;

    // classify incoming transfers
    tklp_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .qstat    (qstat),
        .wr       (wr)
    );

    // short queue between the two parts
    tklp_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .qstat (qstat),
        .head  (head)
    );

    // key state and results
    tklp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// File: rtl/tklp_front.sv
`default_nettype none

module tklp_front
(
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tklp_pkg::IN_DATA_W-1:0] s_tdata,  // status_main, status_aux, motor_busy
    input  wire logic                           s_tuser,  // mode
    input  wire tklp_pkg::tklp_qstat_t          qstat,
    output tklp_pkg::tklp_push_t                wr
);

    logic [tklp_pkg::CODE_W-1:0] status_main;
    logic [tklp_pkg::CODE_W-1:0] status_aux;
    logic                        motor_busy;

    // unpack the transfer
    assign status_main = s_tdata[7:0];
    assign status_aux  = s_tdata[15:8];
    assign motor_busy  = s_tdata[16];

    assign s_tready = !qstat.full;

    // decide the item kind
    always_comb
    begin
        wr.push              = s_tvalid && !qstat.full;
        wr.entry.status_main = status_main;
        wr.entry.status_aux  = status_aux;
        if (!s_tuser)
        begin
            wr.entry.kind = tklp_pkg::KIND_TICK;
        end
        else if (motor_busy)
        begin
            wr.entry.kind = tklp_pkg::KIND_BUSY;
        end
        else if ((status_main == '0) == (status_aux == '0))
        begin
            wr.entry.kind = tklp_pkg::KIND_CLEAR;
        end
        else
        begin
            wr.entry.kind = tklp_pkg::KIND_SCAN;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tklp_queue.sv
`default_nettype none

module tklp_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tklp_pkg::tklp_push_t wr,
    input  wire logic                 pop,
    output tklp_pkg::tklp_qstat_t     qstat,
    output tklp_pkg::tklp_entry_t     head
);

    tklp_pkg::tklp_entry_t              mem_reg [tklp_pkg::QUEUE_DEPTH];
    logic [tklp_pkg::QPTR_W-1:0]        head_reg;
    logic [tklp_pkg::QPTR_W-1:0]        head_next;
    logic [tklp_pkg::QPTR_W-1:0]        tail_reg;
    logic [tklp_pkg::QPTR_W-1:0]        tail_next;
    logic [tklp_pkg::QCNT_W-1:0]        count_reg;
    logic [tklp_pkg::QCNT_W-1:0]        count_next;

    assign qstat.full  = (count_reg == tklp_pkg::QCNT_W'(tklp_pkg::QUEUE_DEPTH));
    assign qstat.valid = (count_reg != '0);
    assign head        = mem_reg[head_reg];

    // pointer and fill count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (wr.push)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = head_reg + 1'b1;
        end
        if (wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[tail_reg] <= wr.entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tklp_back.sv
`default_nettype none

`include "touch_key_long_press_classifier_top_macros.svh"

module tklp_back
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [2:0]                      cfg_index,
    input  wire logic [tklp_pkg::CFG_W-1:0]      cfg_data,
    input  wire tklp_pkg::tklp_qstat_t           qstat,
    input  wire tklp_pkg::tklp_entry_t           head,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tklp_pkg::OUT_DATA_W-1:0]      m_tdata   // key_event, key_touched
);

    // configuration registers
    logic [tklp_pkg::CODE_W-1:0] power_code_reg;
    logic [tklp_pkg::CODE_W-1:0] speed_code_reg;
    logic [tklp_pkg::CODE_W-1:0] timer_code_reg;
    logic [tklp_pkg::CODE_W-1:0] mode_code_reg;
    logic [tklp_pkg::CODE_W-1:0] wifi_code_reg;
    logic [tklp_pkg::HOLD_W-1:0] hold_ticks_reg;
    logic [tklp_pkg::REP_W-1:0]  short_rep_reg;
    logic [tklp_pkg::REP_W-1:0]  long_rep_reg;

    // classifier state
    logic                        counting_reg, counting_next;
    logic [tklp_pkg::HOLD_W-1:0] hold_count_reg, hold_count_next;
    logic                        touched_reg, touched_next;
    tklp_pkg::tklp_event_t       cur_key_reg, cur_key_next;
    logic [tklp_pkg::CODE_W-1:0] prev_main_reg, prev_main_next;
    logic [tklp_pkg::CODE_W-1:0] prev_aux_reg, prev_aux_next;
    logic [tklp_pkg::REP_W-1:0]  wifi_rep_reg, wifi_rep_next;
    logic [tklp_pkg::REP_W-1:0]  timer_rep_reg, timer_rep_next;
    logic [tklp_pkg::REP_W-1:0]  mode_rep_reg, mode_rep_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    tklp_pkg::tklp_event_t       out_event_reg, out_event_next;
    logic                        out_touched_reg, out_touched_next;

    logic [tklp_pkg::CODE_W-1:0] m;
    logic [tklp_pkg::CODE_W-1:0] a;

    function automatic logic [tklp_pkg::REP_W-1:0] sat_inc(input logic [tklp_pkg::REP_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    assign m        = head.status_main;
    assign a        = head.status_aux;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_touched_reg, out_event_reg};

    // ticks never need the output slot
    assign pop = qstat.valid &&
                 (head.kind == tklp_pkg::KIND_TICK || !out_valid_reg || m_tready);

    // state update for the popped item
    always_comb
    begin
        counting_next    = counting_reg;
        hold_count_next  = hold_count_reg;
        touched_next     = touched_reg;
        cur_key_next     = cur_key_reg;
        prev_main_next   = prev_main_reg;
        prev_aux_next    = prev_aux_reg;
        wifi_rep_next    = wifi_rep_reg;
        timer_rep_next   = timer_rep_reg;
        mode_rep_next    = mode_rep_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_event_next   = out_event_reg;
        out_touched_next = out_touched_reg;
        if (pop)
        begin
            unique case (head.kind)
                tklp_pkg::KIND_TICK:
                begin
                    if (counting_reg && hold_count_reg != '1)
                    begin
                        hold_count_next = hold_count_reg + 1'b1;
                    end
                end
                tklp_pkg::KIND_BUSY:
                begin
                    out_valid_next   = 1'b1;
                    out_event_next   = tklp_pkg::EV_BUSY;
                    out_touched_next = 1'b0;
                end
                tklp_pkg::KIND_CLEAR:
                begin
                    counting_next    = 1'b0;
                    hold_count_next  = '0;
                    touched_next     = 1'b0;
                    cur_key_next     = tklp_pkg::EV_NONE;
                    prev_main_next   = '0;
                    prev_aux_next    = '0;
                    wifi_rep_next    = '0;
                    timer_rep_next   = '0;
                    mode_rep_next    = '0;
                    out_valid_next   = 1'b1;
                    out_event_next   = tklp_pkg::EV_NONE;
                    out_touched_next = 1'b0;
                end
                tklp_pkg::KIND_SCAN:
                begin
                    // changed status restarts qualification
                    if ((m != '0 && m != prev_main_reg) || (a != '0 && a != prev_aux_reg))
                    begin
                        counting_next   = 1'b1;
                        hold_count_next = '0;
                        touched_next    = 1'b0;
                        cur_key_next    = tklp_pkg::EV_NONE;
                    end
                    // hold reached: qualification check
                    if (hold_count_next >= hold_ticks_reg)
                    begin
                        if (a != wifi_code_reg && a != timer_code_reg && a != mode_code_reg)
                        begin
                            counting_next   = 1'b0;
                            hold_count_next = '0;
                            wifi_rep_next   = '0;
                            timer_rep_next  = '0;
                            mode_rep_next   = '0;
                        end
                        else
                        begin
                            hold_count_next = '0;
                        end
                        if (m != '0)
                        begin
                            if (m == power_code_reg)
                            begin
                                touched_next = 1'b1;
                                cur_key_next = tklp_pkg::EV_POWER;
                            end
                            else
                            begin
                                touched_next = 1'b0;
                                cur_key_next = tklp_pkg::EV_NONE;
                            end
                            wifi_rep_next = '0;
                        end
                        if (a != '0)
                        begin
                            if (a == speed_code_reg)
                            begin
                                touched_next = 1'b1;
                                cur_key_next = tklp_pkg::EV_SPEED;
                            end
                            else if (a == timer_code_reg)
                            begin
                                timer_rep_next = sat_inc(timer_rep_next);
                                if (timer_rep_next >= short_rep_reg)
                                begin
                                    touched_next    = 1'b1;
                                    cur_key_next    = tklp_pkg::EV_TIMER;
                                    counting_next   = 1'b0;
                                    hold_count_next = '0;
                                end
                            end
                            else if (a == mode_code_reg)
                            begin
                                mode_rep_next = sat_inc(mode_rep_next);
                                if (mode_rep_next >= short_rep_reg)
                                begin
                                    touched_next    = 1'b1;
                                    cur_key_next    = tklp_pkg::EV_MODE;
                                    counting_next   = 1'b0;
                                    hold_count_next = '0;
                                end
                            end
                            else if (a == wifi_code_reg)
                            begin
                                wifi_rep_next = sat_inc(wifi_rep_next);
                                if (wifi_rep_next >= long_rep_reg)
                                begin
                                    touched_next    = 1'b1;
                                    cur_key_next    = tklp_pkg::EV_WIFI;
                                    counting_next   = 1'b0;
                                    hold_count_next = '0;
                                end
                            end
                            else
                            begin
                                touched_next = 1'b0;
                                cur_key_next = tklp_pkg::EV_NONE;
                            end
                        end
                    end
                    prev_main_next   = m;
                    prev_aux_next    = a;
                    out_valid_next   = 1'b1;
                    out_event_next   = cur_key_next;
                    out_touched_next = touched_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_code_reg <= tklp_pkg::RST_POWER_CODE;
            speed_code_reg <= tklp_pkg::RST_SPEED_CODE;
            timer_code_reg <= tklp_pkg::RST_TIMER_CODE;
            mode_code_reg  <= tklp_pkg::RST_MODE_CODE;
            wifi_code_reg  <= tklp_pkg::RST_WIFI_CODE;
            hold_ticks_reg <= tklp_pkg::RST_HOLD_TICKS;
            short_rep_reg  <= tklp_pkg::RST_SHORT_REP;
            long_rep_reg   <= tklp_pkg::RST_LONG_REP;
        end
        else if (cfg_we)
        begin
            unique case (tklp_pkg::tklp_reg_t'(cfg_index))
                tklp_pkg::REG_POWER_CODE: power_code_reg <= cfg_data[7:0];
                tklp_pkg::REG_SPEED_CODE: speed_code_reg <= cfg_data[7:0];
                tklp_pkg::REG_TIMER_CODE: timer_code_reg <= cfg_data[7:0];
                tklp_pkg::REG_MODE_CODE:  mode_code_reg  <= cfg_data[7:0];
                tklp_pkg::REG_WIFI_CODE:  wifi_code_reg  <= cfg_data[7:0];
                tklp_pkg::REG_HOLD_TICKS: hold_ticks_reg <= cfg_data;
                tklp_pkg::REG_SHORT_REP:  short_rep_reg  <= cfg_data[7:0];
                tklp_pkg::REG_LONG_REP:   long_rep_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counting_reg    <= 1'b0;
            hold_count_reg  <= '0;
            touched_reg     <= 1'b0;
            cur_key_reg     <= tklp_pkg::EV_NONE;
            prev_main_reg   <= '0;
            prev_aux_reg    <= '0;
            wifi_rep_reg    <= '0;
            timer_rep_reg   <= '0;
            mode_rep_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            counting_reg    <= counting_next;
            hold_count_reg  <= hold_count_next;
            touched_reg     <= touched_next;
            cur_key_reg     <= cur_key_next;
            prev_main_reg   <= prev_main_next;
            prev_aux_reg    <= prev_aux_next;
            wifi_rep_reg    <= wifi_rep_next;
            timer_rep_reg   <= timer_rep_next;
            mode_rep_reg    <= mode_rep_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_event_reg   <= out_event_next;
        out_touched_reg <= out_touched_next;
    end

    // checks
    `TKLP_ASSERT_NEXT(a_clear_resets, clk, rst_n,
        pop && head.kind == tklp_pkg::KIND_CLEAR,
        !counting_reg && hold_count_reg == '0 && wifi_rep_reg == '0 &&
        timer_rep_reg == '0 && mode_rep_reg == '0)
    `TKLP_ASSERT_NEXT(a_busy_result, clk, rst_n,
        pop && head.kind == tklp_pkg::KIND_BUSY,
        out_valid_reg && out_event_reg == tklp_pkg::EV_BUSY && !out_touched_reg)
    `TKLP_ASSERT_NOW(a_touched_key, clk, rst_n,
        1'b1,
        touched_reg == (cur_key_reg != tklp_pkg::EV_NONE))

endmodule

`default_nettype wire
